/* rtl/vai_pkg.sv */
package vai_pkg;

    localparam int DEPTH_DEFAULT = 1024;
    localparam int POS_W         = 10;
    localparam int VAL_W         = 32;

    typedef enum logic [1:0] {
        CMD_WRITE = 2'd0,
        CMD_QUERY = 2'd1,
        CMD_CLEAR = 2'd2
    } cmd_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_STAMP,
        ST_CHECK
    } state_t;

endpackage

/* rtl/virtual_array_initializer.sv */
// A query passes the stamp and check states and raises its registered
// response once the check state finds the response slot free; in-range
// writes take the same path, clears and unused commands stay in idle. A new
// write or query is taken only back in idle, after the two dependent memory
// reads (stamp of position, then position of stamp). Reset clears only the
// init count and control state; the memories need no clearing pass.
module virtual_array_initializer
    import vai_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEFAULT
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    req_valid,
    output logic                    req_ready,
    input  logic [1:0]              cmd,
    input  logic [POS_W-1:0]        pos,
    input  logic signed [VAL_W-1:0] val,
    output logic                    rsp_valid,
    input  logic                    rsp_ready,
    output logic signed [VAL_W-1:0] value,
    output logic                    status
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [VAL_W-1:0] value_mem [DEPTH];
    logic [CW-1:0]    stamp_mem [DEPTH];
    logic [POS_W-1:0] owner_mem [DEPTH+1];

    state_t state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic rsp_valid_reg, rsp_valid_next;
    logic signed [VAL_W-1:0] value_reg, value_next;
    logic status_reg, status_next;

    logic is_query_reg, is_query_next;
    logic pos_ok_reg, pos_ok_next;
    logic [POS_W-1:0] pos_reg, pos_next;
    logic [VAL_W-1:0] val_reg, val_next;
    logic in_range_reg, in_range_next;

    logic [VAL_W-1:0] value_rd_reg;
    logic [CW-1:0]    stamp_rd_reg;
    logic [POS_W-1:0] owner_rd_reg;

    logic          rd_first;
    logic          rd_owner;
    logic          wr_value;
    logic          wr_stamp;
    logic [AW-1:0] pos_idx;
    logic [AW-1:0] pos_reg_idx;
    logic [CW-1:0] new_stamp;
    logic          hit;
    logic          pos_in_bounds;

    assign pos_idx       = AW'(pos);
    assign pos_reg_idx   = AW'(pos_reg);
    assign new_stamp     = count_reg + CW'(1);
    assign hit           = in_range_reg && (owner_rd_reg == pos_reg);
    assign pos_in_bounds = (32'(pos) < DEPTH);

    always_ff @(posedge clk)
    begin
        if (rd_first)
        begin
            value_rd_reg <= value_mem[pos_idx];
            stamp_rd_reg <= stamp_mem[pos_idx];
        end
        if (rd_owner)
        begin
            owner_rd_reg <= owner_mem[stamp_rd_reg];
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_value)
        begin
            value_mem[pos_reg_idx] <= val_reg;
        end
        if (wr_stamp)
        begin
            stamp_mem[pos_reg_idx] <= new_stamp;
            owner_mem[new_stamp]   <= pos_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg    <= value_next;
        status_reg   <= status_next;
        is_query_reg <= is_query_next;
        pos_ok_reg   <= pos_ok_next;
        pos_reg      <= pos_next;
        val_reg      <= val_next;
        in_range_reg <= in_range_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        rsp_valid_next = rsp_valid_reg && !rsp_ready;
        value_next     = value_reg;
        status_next    = status_reg;
        is_query_next  = is_query_reg;
        pos_ok_next    = pos_ok_reg;
        pos_next       = pos_reg;
        val_next       = val_reg;
        in_range_next  = in_range_reg;
        req_ready      = 1'b0;
        rd_first       = 1'b0;
        rd_owner       = 1'b0;
        wr_value       = 1'b0;
        wr_stamp       = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    pos_next      = pos;
                    val_next      = val;
                    pos_ok_next   = pos_in_bounds;
                    is_query_next = (cmd_t'(cmd) == CMD_QUERY);
                    case (cmd_t'(cmd))
                        CMD_WRITE:
                        begin
                            if (pos_in_bounds)
                            begin
                                rd_first   = 1'b1;
                                state_next = ST_STAMP;
                            end
                        end
                        CMD_QUERY:
                        begin
                            rd_first   = pos_in_bounds;
                            state_next = ST_STAMP;
                        end
                        CMD_CLEAR:
                        begin
                            count_next = '0;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_STAMP:
            begin
                if (pos_ok_reg && (stamp_rd_reg != '0) && (stamp_rd_reg <= count_reg))
                begin
                    in_range_next = 1'b1;
                end
                else
                begin
                    in_range_next = 1'b0;
                end
                rd_owner      = in_range_next;
                state_next    = ST_CHECK;
            end
            ST_CHECK:
            begin
                if (is_query_reg)
                begin
                    if (!rsp_valid_reg || rsp_ready)
                    begin
                        rsp_valid_next = 1'b1;
                        value_next     = hit ? $signed(value_rd_reg) : '0;
                        status_next    = !hit;
                        state_next     = ST_IDLE;
                    end
                end
                else
                begin
                    if (hit)
                    begin
                        wr_value = 1'b1;
                    end
                    else if (32'(count_reg) < DEPTH)
                    begin
                        wr_value   = 1'b1;
                        wr_stamp   = 1'b1;
                        count_next = new_stamp;
                    end
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign rsp_valid = rsp_valid_reg;
    assign value     = value_reg;
    assign status    = status_reg;

    a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        32'(count_reg) <= DEPTH)
        else $error("init count exceeds depth");

    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != $past(count_reg)) |->
            (count_reg == '0 || count_reg == $past(count_reg) + CW'(1)))
        else $error("init count moved by more than one");

    a_rsp_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid_reg) |-> ($past(state_reg) == ST_CHECK && $past(is_query_reg)))
        else $error("response raised outside a query check");

    a_stamp_write_new: assert property (@(posedge clk) disable iff (!rst_n)
        wr_stamp |-> (!hit && !is_query_reg && pos_ok_reg))
        else $error("stamp written for a valid or ignored position");

endmodule
